[hw/rtl/sdmw_pkg.sv]
// Package for the SD card multi-block write sequencer.
// Holds the phase, action, status and error codes, register indexes and the
// struct types that the sequencer core and the top level share.
package sdmw_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WCMD = 3'd1,
        PH_CHK  = 3'd2,
        PH_DATA = 3'd3,
        PH_PROG = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        FN_START     = 2'd0,
        FN_WCMD_DONE = 2'd1,
        FN_STAT_DONE = 2'd2,
        FN_DATA_DONE = 2'd3
    } t_func;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_WCMD  = 3'd1;
    localparam logic [2:0] ACT_STAT  = 3'd2;
    localparam logic [2:0] ACT_STAT1 = 3'd3;
    localparam logic [2:0] ACT_DATA  = 3'd4;
    localparam logic [2:0] ACT_DONE  = 3'd5;
    localparam logic [2:0] ACT_FAIL  = 3'd6;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_CMD_CRC   = 4'd1;
    localparam logic [3:0] ST_RESP_CRC  = 4'd2;
    localparam logic [3:0] ST_DATA_CRC  = 4'd3;
    localparam logic [3:0] ST_GENERAL   = 4'd7;
    localparam logic [3:0] ST_DATA_TOUT = 4'd8;
    localparam logic [3:0] ST_BUSY      = 4'd9;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CMD_CRC  = 3'd1;
    localparam logic [2:0] ERR_RESP_CRC = 3'd2;
    localparam logic [2:0] ERR_DATA_CRC = 3'd3;
    localparam logic [2:0] ERR_RESP_ERR = 3'd4;
    localparam logic [2:0] ERR_OTHER    = 3'd6;
    localparam logic [2:0] ERR_RSVD     = 3'd7;

    localparam logic [3:0] CS_TRAN = 4'd4;
    localparam logic [3:0] CS_RCV  = 4'd6;

    localparam logic [2:0] CFG_HIGH_CAPACITY = 3'd0;
    localparam logic [2:0] CFG_BLOCK_LEN_LOG2 = 3'd1;
    localparam logic [2:0] CFG_RETRY_LIMIT = 3'd2;
    localparam logic [2:0] CFG_PROG_POLL_LIMIT = 3'd3;
    localparam logic [2:0] CFG_CARD_ADDRESS = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic        high_capacity;
        logic [3:0]  block_len_log2;
        logic [3:0]  retry_limit;
        logic [11:0] prog_poll_limit;
        logic [15:0] card_address;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] cmd_arg;
        logic [31:0] block_index;
        logic [31:0] blocks_done;
        logic [3:0]  status;
    } t_result;

endpackage

[hw/rtl/sdmw_if.sv]
// Handshake interfaces of the SD card multi-block write sequencer.
// Input events, result actions and register writes; uses sdmw_pkg widths.
interface sdmw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] start_block;
    logic [31:0] num_blocks;
    logic [2:0]  error_class;
    logic [3:0]  card_state;

    modport source (output valid, func, start_block, num_blocks, error_class,
                    card_state, input ready);
    modport sink (input valid, func, start_block, num_blocks, error_class,
                  card_state, output ready);
endinterface

interface sdmw_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] cmd_arg;
    logic [31:0] block_index;
    logic [31:0] blocks_done;
    logic [3:0]  status;

    modport source (output valid, action, cmd_arg, block_index, blocks_done,
                    status, input ready);
    modport sink (input valid, action, cmd_arg, block_index, blocks_done,
                  status, output ready);
endinterface

interface sdmw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sdmw_pkg::CFG_INDEX_W-1:0] index;
    logic [sdmw_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/sdmw_core.sv]
// Decision logic and operation state of the multi-block write sequencer.
// Depends on sdmw_pkg for codes, the register struct and the result struct.
module sdmw_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_func,
    input  logic [31:0]       i_start_block,
    input  logic [31:0]       i_num_blocks,
    input  logic [2:0]        i_error_class,
    input  logic [3:0]        i_card_state,
    input  sdmw_pkg::t_cfg    i_cfg,
    output sdmw_pkg::t_result o_result
);

    sdmw_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_cur, n_cur;
    logic [31:0] r_tgt, n_tgt;
    logic [31:0] r_done, n_done;
    logic [3:0]  r_cmd_tries, n_cmd_tries;
    logic [11:0] r_stat_tries, n_stat_tries;
    logic [3:0]  r_data_tries, n_data_tries;

    logic [2:0]  err;
    logic [31:0] done_inc;
    logic [31:0] cur_inc;
    logic [31:0] addr_cur;
    logic [31:0] addr_next;
    logic [31:0] addr_start;
    logic        cmd_retry;
    logic        stat_retry;
    logic        data_retry;
    logic        last_block;

    function automatic logic [31:0] blk_addr(input logic [31:0] blk,
                                             input sdmw_pkg::t_cfg cfg);
        if (cfg.high_capacity) begin
            return blk;
        end
        return blk << cfg.block_len_log2;
    endfunction

    assign err        = (i_error_class == sdmw_pkg::ERR_RSVD) ? sdmw_pkg::ERR_OTHER
                                                              : i_error_class;
    assign done_inc   = r_done + 32'd1;
    assign cur_inc    = r_cur + 32'd1;
    assign addr_cur   = blk_addr(r_cur, i_cfg);
    assign addr_next  = blk_addr(cur_inc, i_cfg);
    assign addr_start = blk_addr(i_start_block, i_cfg);
    assign cmd_retry  = r_cmd_tries > 4'd1;
    assign stat_retry = r_stat_tries > 12'd1;
    assign data_retry = r_data_tries > 4'd1;
    assign last_block = done_inc == r_tgt;

    // Result of the current event.
    always_comb begin
        o_result = '0;
        case (i_func)
            sdmw_pkg::FN_START: begin
                if (r_phase != sdmw_pkg::PH_IDLE) begin
                    o_result.action = sdmw_pkg::ACT_FAIL;
                    o_result.status = sdmw_pkg::ST_BUSY;
                end else if (i_num_blocks == 32'd0) begin
                    o_result.action = sdmw_pkg::ACT_DONE;
                end else begin
                    o_result.action  = sdmw_pkg::ACT_WCMD;
                    o_result.cmd_arg = addr_start;
                end
            end
            sdmw_pkg::FN_WCMD_DONE: begin
                if (r_phase == sdmw_pkg::PH_WCMD) begin
                    if (err == sdmw_pkg::ERR_NONE) begin
                        o_result.action      = sdmw_pkg::ACT_DATA;
                        o_result.block_index = r_done;
                    end else if (err == sdmw_pkg::ERR_CMD_CRC && cmd_retry) begin
                        o_result.action  = sdmw_pkg::ACT_WCMD;
                        o_result.cmd_arg = addr_cur;
                    end else if (err == sdmw_pkg::ERR_RESP_CRC) begin
                        o_result.action  = sdmw_pkg::ACT_STAT;
                        o_result.cmd_arg = {16'd0, i_cfg.card_address};
                    end else begin
                        o_result.action      = sdmw_pkg::ACT_FAIL;
                        o_result.blocks_done = r_done;
                        o_result.status      = {1'b0, err};
                    end
                end
            end
            sdmw_pkg::FN_STAT_DONE: begin
                if (r_phase == sdmw_pkg::PH_CHK) begin
                    if (err == sdmw_pkg::ERR_NONE || err == sdmw_pkg::ERR_RESP_ERR) begin
                        if (i_card_state == sdmw_pkg::CS_TRAN && cmd_retry) begin
                            o_result.action  = sdmw_pkg::ACT_WCMD;
                            o_result.cmd_arg = addr_cur;
                        end else if (i_card_state == sdmw_pkg::CS_TRAN) begin
                            o_result.action      = sdmw_pkg::ACT_FAIL;
                            o_result.blocks_done = r_done;
                            o_result.status      = sdmw_pkg::ST_CMD_CRC;
                        end else if (i_card_state == sdmw_pkg::CS_RCV) begin
                            o_result.action      = sdmw_pkg::ACT_DATA;
                            o_result.block_index = r_done;
                        end else begin
                            o_result.action      = sdmw_pkg::ACT_FAIL;
                            o_result.blocks_done = r_done;
                            o_result.status      = sdmw_pkg::ST_GENERAL;
                        end
                    end else if (err == sdmw_pkg::ERR_RESP_CRC && stat_retry) begin
                        o_result.action  = sdmw_pkg::ACT_STAT;
                        o_result.cmd_arg = {16'd0, i_cfg.card_address};
                    end else begin
                        o_result.action      = sdmw_pkg::ACT_FAIL;
                        o_result.blocks_done = r_done;
                        o_result.status      = {1'b0, err};
                    end
                end else if (r_phase == sdmw_pkg::PH_PROG) begin
                    if (err == sdmw_pkg::ERR_NONE && i_card_state == sdmw_pkg::CS_TRAN) begin
                        if (last_block) begin
                            o_result.action      = sdmw_pkg::ACT_DONE;
                            o_result.blocks_done = done_inc;
                        end else begin
                            o_result.action  = sdmw_pkg::ACT_WCMD;
                            o_result.cmd_arg = addr_next;
                        end
                    end else if (err == sdmw_pkg::ERR_NONE || err == sdmw_pkg::ERR_CMD_CRC
                                 || err == sdmw_pkg::ERR_RESP_CRC) begin
                        if (stat_retry) begin
                            o_result.action  = sdmw_pkg::ACT_STAT1;
                            o_result.cmd_arg = {16'd0, i_cfg.card_address};
                        end else begin
                            o_result.action      = sdmw_pkg::ACT_FAIL;
                            o_result.blocks_done = r_done;
                            o_result.status      = sdmw_pkg::ST_DATA_TOUT;
                        end
                    end else begin
                        o_result.action      = sdmw_pkg::ACT_FAIL;
                        o_result.blocks_done = r_done;
                        o_result.status      = {1'b0, err};
                    end
                end
            end
            sdmw_pkg::FN_DATA_DONE: begin
                if (r_phase == sdmw_pkg::PH_DATA) begin
                    if (err == sdmw_pkg::ERR_NONE) begin
                        o_result.action  = sdmw_pkg::ACT_STAT;
                        o_result.cmd_arg = {16'd0, i_cfg.card_address};
                    end else if (err == sdmw_pkg::ERR_DATA_CRC && data_retry) begin
                        o_result.action  = sdmw_pkg::ACT_WCMD;
                        o_result.cmd_arg = addr_cur;
                    end else begin
                        o_result.action      = sdmw_pkg::ACT_FAIL;
                        o_result.blocks_done = r_done;
                        o_result.status      = {1'b0, err};
                    end
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // Next phase and counters.
    always_comb begin
        n_phase      = r_phase;
        n_cur        = r_cur;
        n_tgt        = r_tgt;
        n_done       = r_done;
        n_cmd_tries  = r_cmd_tries;
        n_stat_tries = r_stat_tries;
        n_data_tries = r_data_tries;
        case (i_func)
            sdmw_pkg::FN_START: begin
                if (r_phase == sdmw_pkg::PH_IDLE) begin
                    n_cur  = i_start_block;
                    n_tgt  = i_num_blocks;
                    n_done = 32'd0;
                    if (i_num_blocks != 32'd0) begin
                        n_data_tries = i_cfg.retry_limit;
                        n_cmd_tries  = i_cfg.retry_limit;
                        n_phase      = sdmw_pkg::PH_WCMD;
                    end
                end
            end
            sdmw_pkg::FN_WCMD_DONE: begin
                if (r_phase == sdmw_pkg::PH_WCMD) begin
                    if (err == sdmw_pkg::ERR_NONE) begin
                        n_phase = sdmw_pkg::PH_DATA;
                    end else if (err == sdmw_pkg::ERR_CMD_CRC && cmd_retry) begin
                        n_cmd_tries = r_cmd_tries - 4'd1;
                    end else if (err == sdmw_pkg::ERR_RESP_CRC) begin
                        n_stat_tries = {8'd0, i_cfg.retry_limit};
                        n_phase      = sdmw_pkg::PH_CHK;
                    end else begin
                        n_phase = sdmw_pkg::PH_IDLE;
                    end
                end
            end
            sdmw_pkg::FN_STAT_DONE: begin
                if (r_phase == sdmw_pkg::PH_CHK) begin
                    if (err == sdmw_pkg::ERR_NONE || err == sdmw_pkg::ERR_RESP_ERR) begin
                        if (i_card_state == sdmw_pkg::CS_TRAN && cmd_retry) begin
                            n_cmd_tries = r_cmd_tries - 4'd1;
                            n_phase     = sdmw_pkg::PH_WCMD;
                        end else if (i_card_state == sdmw_pkg::CS_RCV) begin
                            n_phase = sdmw_pkg::PH_DATA;
                        end else begin
                            n_phase = sdmw_pkg::PH_IDLE;
                        end
                    end else if (err == sdmw_pkg::ERR_RESP_CRC && stat_retry) begin
                        n_stat_tries = r_stat_tries - 12'd1;
                    end else begin
                        n_phase = sdmw_pkg::PH_IDLE;
                    end
                end else if (r_phase == sdmw_pkg::PH_PROG) begin
                    if (err == sdmw_pkg::ERR_NONE && i_card_state == sdmw_pkg::CS_TRAN) begin
                        n_done = done_inc;
                        if (last_block) begin
                            n_phase = sdmw_pkg::PH_IDLE;
                        end else begin
                            n_cur        = cur_inc;
                            n_data_tries = i_cfg.retry_limit;
                            n_cmd_tries  = i_cfg.retry_limit;
                            n_phase      = sdmw_pkg::PH_WCMD;
                        end
                    end else if ((err == sdmw_pkg::ERR_NONE || err == sdmw_pkg::ERR_CMD_CRC
                                  || err == sdmw_pkg::ERR_RESP_CRC) && stat_retry) begin
                        n_stat_tries = r_stat_tries - 12'd1;
                    end else begin
                        n_phase = sdmw_pkg::PH_IDLE;
                    end
                end
            end
            sdmw_pkg::FN_DATA_DONE: begin
                if (r_phase == sdmw_pkg::PH_DATA) begin
                    if (err == sdmw_pkg::ERR_NONE) begin
                        n_stat_tries = i_cfg.prog_poll_limit;
                        n_phase      = sdmw_pkg::PH_PROG;
                    end else if (err == sdmw_pkg::ERR_DATA_CRC && data_retry) begin
                        n_data_tries = r_data_tries - 4'd1;
                        n_cmd_tries  = i_cfg.retry_limit;
                        n_phase      = sdmw_pkg::PH_WCMD;
                    end else begin
                        n_phase = sdmw_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sdmw_pkg::PH_IDLE;
            r_cur        <= '0;
            r_tgt        <= '0;
            r_done       <= '0;
            r_cmd_tries  <= '0;
            r_stat_tries <= '0;
            r_data_tries <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_cur        <= n_cur;
            r_tgt        <= n_tgt;
            r_done       <= n_done;
            r_cmd_tries  <= n_cmd_tries;
            r_stat_tries <= n_stat_tries;
            r_data_tries <= n_data_tries;
        end
    end

endmodule

[hw/rtl/sd_multiblock_write_sequencer.sv]
// Top level of the SD card multi-block write sequencer.
// Depends on sdmw_pkg, the interfaces in sdmw_if.sv and sdmw_core.
//
// Every accepted event (start request or completion of a write command,
// status command or data transfer) yields exactly one action, registered and
// presented on the result channel in the cycle after the transfer unless an
// earlier result is still waiting. An event can be accepted in every cycle;
// a two-entry result buffer keeps input ready high while one result waits to
// be taken, and input ready drops only when both entries are full. Registers
// are written through the configuration channel, which is always ready, and
// should be changed only while idle.
module sd_multiblock_write_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdmw_in_if.sink       i_in,
    sdmw_out_if.source    o_out,
    sdmw_cfg_if.sink      i_cfg
);

    sdmw_pkg::t_cfg    r_cfg;
    sdmw_pkg::t_result result;
    sdmw_pkg::t_result r_out, n_out;
    sdmw_pkg::t_result r_skid, n_skid;
    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    logic              in_take;
    logic              out_take;

    assign i_in.ready  = !r_skid_valid;
    assign i_cfg.ready = 1'b1;
    assign in_take     = i_in.valid && !r_skid_valid;
    assign out_take    = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_capacity   <= 1'b0;
            r_cfg.block_len_log2  <= 4'd9;
            r_cfg.retry_limit     <= 4'd2;
            r_cfg.prog_poll_limit <= 12'd250;
            r_cfg.card_address    <= 16'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sdmw_pkg::CFG_HIGH_CAPACITY: begin
                    r_cfg.high_capacity <= i_cfg.data[0];
                end
                sdmw_pkg::CFG_BLOCK_LEN_LOG2: begin
                    r_cfg.block_len_log2 <= i_cfg.data[3:0];
                end
                sdmw_pkg::CFG_RETRY_LIMIT: begin
                    r_cfg.retry_limit <= i_cfg.data[3:0];
                end
                sdmw_pkg::CFG_PROG_POLL_LIMIT: begin
                    r_cfg.prog_poll_limit <= i_cfg.data[11:0];
                end
                sdmw_pkg::CFG_CARD_ADDRESS: begin
                    r_cfg.card_address <= i_cfg.data[15:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    sdmw_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_take),
        .i_func        (i_in.func),
        .i_start_block (i_in.start_block),
        .i_num_blocks  (i_in.num_blocks),
        .i_error_class (i_in.error_class),
        .i_card_state  (i_in.card_state),
        .i_cfg         (r_cfg),
        .o_result      (result)
    );

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (in_take) begin
            if (n_out_valid) begin
                n_skid       = result;
                n_skid_valid = 1'b1;
            end else begin
                n_out       = result;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.action      = r_out.action;
    assign o_out.cmd_arg     = r_out.cmd_arg;
    assign o_out.block_index = r_out.block_index;
    assign o_out.blocks_done = r_out.blocks_done;
    assign o_out.status      = r_out.status;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the SD card multi-block write sequencer.
// Depends on sdmw_pkg, the interfaces in sdmw_if.sv and the top level
// sd_multiblock_write_sequencer; it predicts each action and checks every transfer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 50;
    localparam logic [3:0] CS_IDLE = 4'd0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sdmw_in_if  in_bus ();
    sdmw_out_if out_bus ();
    sdmw_cfg_if cfg_bus ();

    sd_multiblock_write_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    sdmw_pkg::t_cfg   seq_cfg;
    sdmw_pkg::t_phase seq_phase;
    logic [31:0] cur_blk;
    logic [31:0] tgt_blks;
    logic [31:0] blks_written;
    logic [3:0]  cmd_tries;
    logic [11:0] stat_tries;
    logic [3:0]  data_tries;

    sdmw_pkg::t_result pending_actions[$];
    logic [2:0]  last_action;
    bit          steady;
    int          hold_req;
    int          cycle_count;
    int          mismatches;
    int          events_sent;
    int          events_ignored;
    int          actions_checked;
    int          settings_applied;
    int          in_stall_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic sdmw_pkg::t_result write_result();
        sdmw_pkg::t_result r;
        r = '0;
        seq_phase = sdmw_pkg::PH_WCMD;
        r.action = sdmw_pkg::ACT_WCMD;
        r.cmd_arg = seq_cfg.high_capacity ? cur_blk : cur_blk << seq_cfg.block_len_log2;
        return r;
    endfunction

    function automatic sdmw_pkg::t_result first_write_result();
        cmd_tries = seq_cfg.retry_limit;
        return write_result();
    endfunction

    function automatic sdmw_pkg::t_result data_result();
        sdmw_pkg::t_result r;
        r = '0;
        seq_phase = sdmw_pkg::PH_DATA;
        r.action = sdmw_pkg::ACT_DATA;
        r.block_index = blks_written;
        return r;
    endfunction

    function automatic sdmw_pkg::t_result poll_result(input logic [2:0] act);
        sdmw_pkg::t_result r;
        r = '0;
        r.action = act;
        r.cmd_arg = {16'h0000, seq_cfg.card_address};
        return r;
    endfunction

    function automatic sdmw_pkg::t_result fail_result(input logic [3:0] st);
        sdmw_pkg::t_result r;
        r = '0;
        seq_phase = sdmw_pkg::PH_IDLE;
        r.action = sdmw_pkg::ACT_FAIL;
        r.blocks_done = blks_written;
        r.status = st;
        return r;
    endfunction

    function automatic sdmw_pkg::t_result next_sd_action(input sdmw_pkg::t_func f,
            input logic [31:0] sb, input logic [31:0] bc, input logic [2:0] ec_in,
            input logic [3:0] cs);
        sdmw_pkg::t_result r;
        logic [2:0]        ec;
        r = '0;
        r.action = sdmw_pkg::ACT_NONE;
        ec = (ec_in == sdmw_pkg::ERR_RSVD) ? sdmw_pkg::ERR_OTHER : ec_in;
        if (f == sdmw_pkg::FN_START) begin
            if (seq_phase != sdmw_pkg::PH_IDLE) begin
                r.action = sdmw_pkg::ACT_FAIL;
                r.status = sdmw_pkg::ST_BUSY;
            end else begin
                cur_blk = sb;
                tgt_blks = bc;
                blks_written = '0;
                if (bc == 32'd0) begin
                    r.action = sdmw_pkg::ACT_DONE;
                end else begin
                    data_tries = seq_cfg.retry_limit;
                    r = first_write_result();
                end
            end
        end else if (f == sdmw_pkg::FN_WCMD_DONE && seq_phase == sdmw_pkg::PH_WCMD) begin
            if (ec == sdmw_pkg::ERR_NONE) begin
                r = data_result();
            end else if (ec == sdmw_pkg::ERR_CMD_CRC) begin
                if (cmd_tries > 1) begin
                    cmd_tries--;
                    r = write_result();
                end else begin
                    r = fail_result(sdmw_pkg::ST_CMD_CRC);
                end
            end else if (ec == sdmw_pkg::ERR_RESP_CRC) begin
                stat_tries = 12'(seq_cfg.retry_limit);
                seq_phase = sdmw_pkg::PH_CHK;
                r = poll_result(sdmw_pkg::ACT_STAT);
            end else begin
                r = fail_result({1'b0, ec});
            end
        end else if (f == sdmw_pkg::FN_STAT_DONE && seq_phase == sdmw_pkg::PH_CHK) begin
            if (ec == sdmw_pkg::ERR_NONE || ec == sdmw_pkg::ERR_RESP_ERR) begin
                if (cs == sdmw_pkg::CS_TRAN) begin
                    if (cmd_tries > 1) begin
                        cmd_tries--;
                        r = write_result();
                    end else begin
                        r = fail_result(sdmw_pkg::ST_CMD_CRC);
                    end
                end else if (cs == sdmw_pkg::CS_RCV) begin
                    r = data_result();
                end else begin
                    r = fail_result(sdmw_pkg::ST_GENERAL);
                end
            end else if (ec == sdmw_pkg::ERR_RESP_CRC) begin
                if (stat_tries > 1) begin
                    stat_tries--;
                    r = poll_result(sdmw_pkg::ACT_STAT);
                end else begin
                    r = fail_result(sdmw_pkg::ST_RESP_CRC);
                end
            end else begin
                r = fail_result({1'b0, ec});
            end
        end else if (f == sdmw_pkg::FN_DATA_DONE && seq_phase == sdmw_pkg::PH_DATA) begin
            if (ec == sdmw_pkg::ERR_NONE) begin
                stat_tries = seq_cfg.prog_poll_limit;
                seq_phase = sdmw_pkg::PH_PROG;
                r = poll_result(sdmw_pkg::ACT_STAT);
            end else if (ec == sdmw_pkg::ERR_DATA_CRC) begin
                if (data_tries > 1) begin
                    data_tries--;
                    r = first_write_result();
                end else begin
                    r = fail_result(sdmw_pkg::ST_DATA_CRC);
                end
            end else begin
                r = fail_result({1'b0, ec});
            end
        end else if (f == sdmw_pkg::FN_STAT_DONE && seq_phase == sdmw_pkg::PH_PROG) begin
            if (ec == sdmw_pkg::ERR_NONE && cs == sdmw_pkg::CS_TRAN) begin
                blks_written++;
                if (blks_written == tgt_blks) begin
                    seq_phase = sdmw_pkg::PH_IDLE;
                    r.action = sdmw_pkg::ACT_DONE;
                    r.blocks_done = blks_written;
                end else begin
                    cur_blk++;
                    data_tries = seq_cfg.retry_limit;
                    r = first_write_result();
                end
            end else if (ec == sdmw_pkg::ERR_NONE || ec == sdmw_pkg::ERR_CMD_CRC
                         || ec == sdmw_pkg::ERR_RESP_CRC) begin
                if (stat_tries > 1) begin
                    stat_tries--;
                    r = poll_result(sdmw_pkg::ACT_STAT1);
                end else begin
                    r = fail_result(sdmw_pkg::ST_DATA_TOUT);
                end
            end else begin
                r = fail_result({1'b0, ec});
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_event(input sdmw_pkg::t_func f, input logic [31:0] sb,
                              input logic [31:0] bc, input logic [2:0] ec,
                              input logic [3:0] cs);
        int                gap;
        sdmw_pkg::t_result act_r;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.func        <= f;
        in_bus.start_block <= sb;
        in_bus.num_blocks  <= bc;
        in_bus.error_class <= ec;
        in_bus.card_state  <= cs;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        act_r = next_sd_action(f, sb, bc, ec, cs);
        pending_actions.push_back(act_r);
        last_action = act_r.action;
        events_sent++;
        if (act_r.action == sdmw_pkg::ACT_NONE) begin
            events_ignored++;
        end
    endtask

    task automatic send_random_event();
        sdmw_pkg::t_func f;
        logic [31:0]     sb;
        logic [31:0]     bc;
        logic [2:0]      ec;
        logic [3:0]      cs;
        int              r;
        sb = $urandom();
        bc = $urandom();
        cs = 4'($urandom_range(0, 15));
        ec = ($urandom_range(0, 99) < 70) ? sdmw_pkg::ERR_NONE : 3'($urandom_range(0, 7));
        case (seq_phase)
            sdmw_pkg::PH_IDLE: f = sdmw_pkg::FN_START;
            sdmw_pkg::PH_WCMD: f = sdmw_pkg::FN_WCMD_DONE;
            sdmw_pkg::PH_DATA: f = sdmw_pkg::FN_DATA_DONE;
            default: f = sdmw_pkg::FN_STAT_DONE;
        endcase
        if ($urandom_range(0, 99) < 10) begin
            f = sdmw_pkg::t_func'(2'($urandom_range(0, 3)));
        end
        r = $urandom_range(0, 99);
        if (f == sdmw_pkg::FN_START) begin
            if (r < 10) begin
                bc = 32'd0;
            end else if (r < 85) begin
                bc = $urandom_range(1, 4);
            end else if (r < 93) begin
                bc = $urandom_range(5, 12);
            end
            if ($urandom_range(0, 3) == 0) begin
                sb = 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
        end else if (seq_phase == sdmw_pkg::PH_CHK) begin
            if (r < 45) begin
                cs = sdmw_pkg::CS_RCV;
            end else if (r < 80) begin
                cs = sdmw_pkg::CS_TRAN;
            end
        end else if (seq_phase == sdmw_pkg::PH_PROG && r < 65) begin
            cs = sdmw_pkg::CS_TRAN;
        end
        send_event(f, sb, bc, ec, cs);
    endtask

    task automatic drain_actions();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        case (idx)
            sdmw_pkg::CFG_HIGH_CAPACITY:   seq_cfg.high_capacity = val[0];
            sdmw_pkg::CFG_BLOCK_LEN_LOG2:  seq_cfg.block_len_log2 = val[3:0];
            sdmw_pkg::CFG_RETRY_LIMIT:     seq_cfg.retry_limit = val[3:0];
            sdmw_pkg::CFG_PROG_POLL_LIMIT: seq_cfg.prog_poll_limit = val[11:0];
            sdmw_pkg::CFG_CARD_ADDRESS:    seq_cfg.card_address = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic hc, input logic [3:0] bl, input logic [3:0] rl,
                                  input logic [11:0] pl, input logic [15:0] ca);
        drain_actions();
        write_register(sdmw_pkg::CFG_HIGH_CAPACITY, 16'(hc));
        write_register(sdmw_pkg::CFG_BLOCK_LEN_LOG2, 16'(bl));
        write_register(sdmw_pkg::CFG_RETRY_LIMIT, 16'(rl));
        write_register(sdmw_pkg::CFG_PROG_POLL_LIMIT, 16'(pl));
        write_register(sdmw_pkg::CFG_CARD_ADDRESS, ca);
        settings_applied++;
    endtask

    task automatic test_retry_paths();
        send_event(sdmw_pkg::FN_DATA_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_START, 32'h0040_0001, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_START, 32'd5, 32'd2, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, sdmw_pkg::ERR_RSVD, 4'hF);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, sdmw_pkg::CS_TRAN);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_CMD_CRC, CS_IDLE);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_RESP_CRC, CS_IDLE);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_RESP_CRC, CS_IDLE);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_RESP_ERR,
                   sdmw_pkg::CS_RCV);
        send_event(sdmw_pkg::FN_DATA_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_DATA_CRC, CS_IDLE);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_DATA_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_CMD_CRC,
                   sdmw_pkg::CS_RCV);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, sdmw_pkg::CS_TRAN);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_RESP_CRC, CS_IDLE);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, sdmw_pkg::CS_TRAN);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_CMD_CRC, CS_IDLE);
        drain_actions();
    endtask

    task automatic test_failure_codes();
        apply_settings(1'b0, 4'd15, 4'd1, 12'd1, 16'hFFFF);
        send_event(sdmw_pkg::FN_START, 32'hFFFF_FFFF, 32'd3, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_DATA_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, sdmw_pkg::CS_TRAN);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_DATA_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, sdmw_pkg::CS_RCV);
        send_event(sdmw_pkg::FN_START, 32'h0001_2345, 32'd1, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_RESP_CRC, CS_IDLE);
        send_event(sdmw_pkg::FN_STAT_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_START, 32'd7, 32'd4, sdmw_pkg::ERR_NONE, CS_IDLE);
        send_event(sdmw_pkg::FN_WCMD_DONE, 32'd0, 32'd0, sdmw_pkg::ERR_RSVD, CS_IDLE);
        drain_actions();
    endtask

    task automatic test_input_backpressure();
        steady = 1'b1;
        hold_req = 60;
        repeat (14) send_random_event();
        steady = 1'b0;
        while (seq_phase != sdmw_pkg::PH_IDLE) send_random_event();
        drain_actions();
    endtask

    task automatic test_random_traffic(input int n_actions);
        int counted;
        int steady_at;
        counted = 0;
        steady_at = $urandom_range(0, n_actions - 25);
        while (counted < n_actions) begin
            steady = (counted >= steady_at && counted < steady_at + 20);
            send_random_event();
            if (last_action != sdmw_pkg::ACT_NONE) begin
                counted++;
            end
        end
        steady = 1'b0;
        while (seq_phase != sdmw_pkg::PH_IDLE) send_random_event();
        drain_actions();
    endtask

    always @(posedge i_clk) begin
        sdmw_pkg::t_result exp_r;
        if (i_rst_n && in_bus.valid && !in_bus.ready) begin
            in_stall_cycles++;
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_actions.size() == 0) begin
                report_mismatch($sformatf("action %0d with nothing outstanding",
                                          out_bus.action));
            end else begin
                exp_r = pending_actions.pop_front();
                actions_checked++;
                if (out_bus.action !== exp_r.action)
                    report_mismatch($sformatf("action %0d, predicted %0d",
                                              out_bus.action, exp_r.action));
                if (out_bus.cmd_arg !== exp_r.cmd_arg)
                    report_mismatch($sformatf("cmd_arg %h, predicted %h",
                                              out_bus.cmd_arg, exp_r.cmd_arg));
                if (out_bus.block_index !== exp_r.block_index)
                    report_mismatch($sformatf("block_index %0d, predicted %0d",
                                              out_bus.block_index, exp_r.block_index));
                if (out_bus.blocks_done !== exp_r.blocks_done)
                    report_mismatch($sformatf("blocks_done %0d, predicted %0d",
                                              out_bus.blocks_done, exp_r.blocks_done));
                if (out_bus.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              out_bus.status, exp_r.status));
            end
        end
    end

    initial begin
        int hold_left;
        int r;
        hold_left = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                out_bus.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    hold_left = $urandom_range(8, 30);
                    out_bus.ready <= 1'b0;
                end else begin
                    out_bus.ready <= (r < 75);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d actions outstanding.",
                 cycle_count, pending_actions.size());
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.func        = '0;
        in_bus.start_block = '0;
        in_bus.num_blocks  = '0;
        in_bus.error_class = '0;
        in_bus.card_state  = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        steady             = 1'b0;
        hold_req           = 0;
        seq_cfg = '{high_capacity: 1'b0, block_len_log2: 4'd9, retry_limit: 4'd2,
                    prog_poll_limit: 12'd250, card_address: 16'h0000};
        seq_phase    = sdmw_pkg::PH_IDLE;
        cur_blk      = '0;
        tgt_blks     = '0;
        blks_written = '0;
        cmd_tries    = '0;
        stat_tries   = '0;
        data_tries   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_retry_paths();
        test_failure_codes();
        apply_settings(1'b0, 4'd9, 4'd2, 12'd250, 16'h1234);
        test_random_traffic(70);
        test_input_backpressure();
        apply_settings(1'b1, 4'd9, 4'd15, 12'd4095, 16'hFFFF);
        test_random_traffic(70);
        apply_settings(1'b0, 4'd11, 4'd1, 12'd1, 16'h0000);
        test_random_traffic(70);
        apply_settings(1'b0, 4'd15, 4'd0, 12'd0, 16'hA5A5);
        test_random_traffic(70);
        apply_settings(1'b0, 4'($urandom_range(0, 15)), 4'($urandom_range(1, 15)),
                       12'($urandom_range(1, 8)), 16'($urandom()));
        test_random_traffic(70);

        $display("Covered %0d events (%0d ignored) over %0d register settings; %0d %s",
                 events_sent, events_ignored, settings_applied, actions_checked,
                 "actions checked.");
        $display("Input held back for %0d cycles by result back-pressure; %0d mismatches.",
                 in_stall_cycles, mismatches);
        if (mismatches == 0 && pending_actions.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
